@@ hdl/sha1_pkg.sv @@
`default_nettype none
package sha1_pkg;

    localparam int RoundW     = 7;
    localparam int LastRound  = 79;
    localparam int LenBytePos = 56;

    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] chain_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              push;
        logic [7:0]        byte_val;
        logic [1:0]        byte_pos;
        logic              step;
        logic              load;
        logic              fold;
        logic              reinit;
        logic [RoundW-1:0] round;
    } ctrl_t;

endpackage
`default_nettype wire

@@ hdl/sha1_msg_if.sv @@
`default_nettype none
interface sha1_msg_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/sha1_digest_if.sv @@
`default_nettype none
interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/sha1_sched.sv @@
`default_nettype none
module sha1_sched (
    input  wire logic           clk,
    input  wire sha1_pkg::ctrl_t ctrl,
    output sha1_pkg::word_t      w0
);
    import sha1_pkg::*;

    logic [23:0] acc_reg;
    word_t       win_reg [16];
    word_t       mix;
    word_t       new_word;

    // window doubles as block store while filling and as W schedule while rounding
    always_comb
    begin
        mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        if (ctrl.step)
        begin
            new_word = {mix[30:0], mix[31]};
        end
        else
        begin
            new_word = {acc_reg, ctrl.byte_val};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            acc_reg <= {acc_reg[15:0], ctrl.byte_val};
        end
        if (ctrl.step || (ctrl.push && ctrl.byte_pos == 2'd3))
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= new_word;
        end
    end

    assign w0 = win_reg[0];

endmodule
`default_nettype wire

@@ hdl/sha1_core.sv @@
`default_nettype none
module sha1_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sha1_pkg::ctrl_t ctrl,
    input  wire sha1_pkg::word_t w,
    output sha1_pkg::chain_t     chain
);
    import sha1_pkg::*;

    localparam chain_t Iv = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                             32'hefcdab89, 32'h67452301};
    localparam word_t K0 = 32'h5a827999;
    localparam word_t K1 = 32'h6ed9eba1;
    localparam word_t K2 = 32'h8f1bbcdc;
    localparam word_t K3 = 32'hca62c1d6;

    chain_t chain_reg;
    word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t  f, k, t;

    always_comb
    begin
        if (ctrl.round < RoundW'(20))
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end
        else if (ctrl.round < RoundW'(40))
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end
        else if (ctrl.round < RoundW'(60))
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctrl.step)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= Iv;
        end
        else if (ctrl.reinit)
        begin
            chain_reg <= Iv;
        end
        else if (ctrl.fold)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

    assign chain = chain_reg;

endmodule
`default_nettype wire

@@ hdl/sha1_hash_engine_unit.sv @@
`default_nettype none
// Channel   Dir  Handshake      Word
// msg       in   valid/ready    kind, data_byte
// digest    out  valid/ready    digest_word, word_index, last_word
//
// A data byte is written straight into the block; the byte that fills a 64-byte block
// then runs 80 rounds of the shared round unit, one per cycle, plus the chaining add.
// Finish writes one padding byte per cycle to the block end, runs one or two
// compressions, then shows the five digest words, one per accepted cycle.
// msg.ready is high only while idle. Reset is immediate: chaining words to the
// initial values, counters cleared. A low digest.ready holds the current word.
module sha1_hash_engine_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sha1_msg_if.sink    msg,
    sha1_digest_if.source digest
);
    import sha1_pkg::*;

    state_t            state_reg, state_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       len_reg, len_next;
    logic [RoundW-1:0] round_reg, round_next;
    logic [2:0]        idx_reg, idx_next;
    logic              pad_reg, pad_next;
    logic              len_ok_reg, len_ok_next;
    logic              last_reg, last_next;
    logic              wr;
    ctrl_t             ctrl;
    word_t             w0;
    chain_t            chain;

    sha1_sched u_sched (
        .clk  (clk),
        .ctrl (ctrl),
        .w0   (w0)
    );

    sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .w     (w0),
        .chain (chain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            round_reg  <= '0;
            idx_reg    <= '0;
            pad_reg    <= 1'b0;
            len_ok_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            pad_reg    <= pad_next;
            len_ok_reg <= len_ok_next;
            last_reg   <= last_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        pad_next      = pad_reg;
        len_ok_next   = len_ok_reg;
        last_next     = last_reg;
        wr            = 1'b0;
        ctrl          = '0;
        ctrl.round    = round_reg;
        msg.ready     = 1'b0;
        digest.valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    wr = 1'b1;
                    if (msg.kind == 1'b0)
                    begin
                        ctrl.byte_val = msg.data_byte;
                        len_next      = len_reg + 64'd8;
                    end
                    else
                    begin
                        ctrl.byte_val = PadByte;
                        pad_next      = 1'b1;
                        len_ok_next   = (fill_reg < 6'(LenBytePos));
                        state_next    = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                wr = 1'b1;
                // length goes out big-endian once the final block reaches its tail
                if (len_ok_reg && fill_reg >= 6'(LenBytePos))
                begin
                    ctrl.byte_val = len_reg[{~fill_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    ctrl.byte_val = 8'h00;
                end
            end
            ST_ROUND:
            begin
                ctrl.step  = 1'b1;
                round_next = round_reg + 1'b1;
                if (round_reg == RoundW'(LastRound))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (!pad_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd4)
                    begin
                        ctrl.reinit = 1'b1;
                        len_next    = '0;
                        pad_next    = 1'b0;
                        len_ok_next = 1'b0;
                        last_next   = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr)
        begin
            ctrl.push     = 1'b1;
            ctrl.byte_pos = fill_reg[1:0];
            fill_next     = fill_reg + 1'b1;
            // block full: load working words and start rounds
            if (fill_reg == 6'd63)
            begin
                ctrl.load  = 1'b1;
                round_next = '0;
                last_next  = pad_next && len_ok_next;
                state_next = ST_ROUND;
            end
        end
    end

    assign digest.digest_word = chain[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == 3'd4);

endmodule
`default_nettype wire

@@ test/sha1_hash_engine_unit_tb.sv @@
`default_nettype none
module sha1_hash_engine_unit_tb;
    import sha1_pkg::*;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam int   STUCK_LIMIT = 3000;
    localparam int   TAIL_CYCLES = 200;

    typedef struct {
        word_t      value;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sha1_msg_if    msg_bus ();
    sha1_digest_if digest_bus ();

    sha1_hash_engine_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_bus),
        .digest (digest_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Running SHA-1 state of the message stream
    word_t       hash_h [5];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] msg_bits;

    digest_word_t pending_digest [$];
    digest_word_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int stuck_cycles   = 0;

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        hash_h[0]  = 32'h67452301;
        hash_h[1]  = 32'hefcdab89;
        hash_h[2]  = 32'h98badcfe;
        hash_h[3]  = 32'h10325476;
        hash_h[4]  = 32'hc3d2e1f0;
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    function automatic void sha1_fold_block();
        word_t sched [80];
        word_t a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 80; i++)
            sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = rotl(a, 5) + f + e + k + sched[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
        block_fill = 0;
    endfunction

    // Absorb one accepted word into the running hash; a finish queues the five digest words.
    function automatic void sha1_absorb(logic kind, logic [7:0] data_byte);
        digest_word_t dw;
        if (kind == KIND_DATA)
        begin
            msg_block[block_fill] = data_byte;
            block_fill++;
            msg_bits += 64'd8;
            if (block_fill == 64)
                sha1_fold_block();
            return;
        end
        msg_block[block_fill] = PadByte;
        block_fill++;
        // no room left for the length: pad out and fold an extra block
        if (block_fill > LenBytePos)
        begin
            while (block_fill < 64)
            begin
                msg_block[block_fill] = 8'h00;
                block_fill++;
            end
            sha1_fold_block();
        end
        while (block_fill < LenBytePos)
        begin
            msg_block[block_fill] = 8'h00;
            block_fill++;
        end
        for (int i = 0; i < 8; i++)
            msg_block[LenBytePos + i] = msg_bits[63 - 8*i -: 8];
        sha1_fold_block();
        for (int i = 0; i < 5; i++)
        begin
            dw.value = hash_h[i];
            dw.index = i[2:0];
            dw.last  = (i == 4);
            pending_digest.push_back(dw);
        end
        sha1_restart();
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
        $display("digest mismatch: %s got %h expected %h", field, got, exp_val);
        mismatches++;
    endtask

    task automatic send_word(logic kind, logic [7:0] data_byte);
        msg_bus.valid     <= 1'b1;
        msg_bus.kind      <= kind;
        msg_bus.data_byte <= data_byte;
        do
            @(posedge clk);
        while (msg_bus.ready !== 1'b1);
        sha1_absorb(kind, data_byte);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            msg_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // Receiver: random stalls, plus a counted hold-off on request
    initial
    begin
        digest_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                digest_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                digest_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (digest_bus.valid === 1'b1 && digest_bus.ready === 1'b1)
            begin
                if (pending_digest.size() == 0)
                    report_mismatch("unexpected word", digest_bus.digest_word, '0);
                else
                begin
                    want = pending_digest.pop_front();
                    if (digest_bus.digest_word !== want.value)
                        report_mismatch("digest_word", digest_bus.digest_word, want.value);
                    if (digest_bus.word_index !== want.index)
                        report_mismatch("word_index", 32'(digest_bus.word_index),
                                        32'(want.index));
                    if (digest_bus.last_word !== want.last)
                        report_mismatch("last_word", 32'(digest_bus.last_word),
                                        32'(want.last));
                end
            end
            if ((msg_bus.valid === 1'b1 && msg_bus.ready === 1'b1) ||
                (digest_bus.valid === 1'b1 && digest_bus.ready === 1'b1))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [7:0] abc [3]   = '{8'h61, 8'h62, 8'h63};
        logic [7:0] ends [6]  = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // empty message, then another right behind it; data_byte is don't-care
        send_word(KIND_FINISH, 8'hff);
        send_word(KIND_FINISH, 8'h00);
        foreach (abc[i])
            send_word(KIND_DATA, abc[i]);
        send_word(KIND_FINISH, 8'h5a);
        foreach (ends[i])
            send_word(KIND_DATA, ends[i]);
        send_word(KIND_FINISH, 8'h00);
        send_word(KIND_DATA, 8'hff);
        send_word(KIND_FINISH, 8'hff);
    endtask

    task automatic test_random_traffic(int n_words, int idle_pct, int stall_pct);
        int unsigned boundary_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        int msg_len;
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_words)
        begin
            // lengths around the padding split and the block edge, else short ones
            if ($urandom_range(0, 3) == 0)
                msg_len = boundary_lens[$urandom_range(0, 7)];
            else
                msg_len = $urandom_range(0, 24);
            // trim the last message so the phase sends its word budget
            if (msg_len > n_words - sent - 1)
                msg_len = n_words - sent - 1;
            repeat (msg_len)
                send_word(KIND_DATA, 8'($urandom_range(0, 255)));
            send_word(KIND_FINISH, 8'($urandom_range(0, 255)));
            sent += msg_len + 1;
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        // keep offering words while the digest side is held off
        repeat (8)
            send_word(KIND_DATA, 8'($urandom_range(0, 255)));
        send_word(KIND_FINISH, 8'h00);
        repeat (12)
            send_word(KIND_DATA, 8'($urandom_range(0, 255)));
        send_word(KIND_FINISH, 8'h00);
        repeat (3)
            send_word(KIND_DATA, 8'($urandom_range(0, 255)));
        send_word(KIND_FINISH, 8'h00);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        msg_bus.valid     = 1'b0;
        msg_bus.kind      = KIND_DATA;
        msg_bus.data_byte = 8'h00;
        sha1_restart();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(70, 0, 0);
        test_random_traffic(70, 71, 0);
        test_random_traffic(70, 0, 71);
        test_random_traffic(70, 16, 16);
        test_backpressure();

        msg_bus.valid  <= 1'b0;
        recv_stall_pct = 0;
        while (pending_digest.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
hdl/sha1_pkg.sv
hdl/sha1_msg_if.sv
hdl/sha1_digest_if.sv
hdl/sha1_sched.sv
hdl/sha1_core.sv
hdl/sha1_hash_engine_unit.sv
test/sha1_hash_engine_unit_tb.sv
